// ===== hdl/lsrc_pkg.sv =====
`default_nettype none
package lsrc_pkg;

  localparam int CW = 16;           // coordinate width
  localparam int NW = CW + 1;       // signed numerator / delta width
  localparam int MW = CW;           // delta magnitude width
  localparam int PW = 2 * CW;       // unsigned product width
  localparam int XW = NW + MW + 1;  // signed cross product width
  localparam int QD = 4;            // queue depth
  localparam int QAW = $clog2(QD);

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [NW-1:0] num_t;
  typedef logic [MW-1:0] mag_t;
  typedef logic [PW-1:0] prod_t;
  typedef logic signed [XW-1:0] xprod_t;

  typedef enum logic [1:0] {
    REG_X_MIN = 2'd0,
    REG_Y_MIN = 2'd1,
    REG_X_MAX = 2'd2,
    REG_Y_MAX = 2'd3
  } reg_idx_t;

  localparam coord_t X_MIN_RST = coord_t'(0);
  localparam coord_t Y_MIN_RST = coord_t'(0);
  localparam coord_t X_MAX_RST = coord_t'(1023);
  localparam coord_t Y_MAX_RST = coord_t'(767);

  typedef struct packed {
    coord_t x_min;
    coord_t y_min;
    coord_t x_max;
    coord_t y_max;
  } win_t;

  // per-segment data that rides along with the parametric math
  typedef struct packed {
    logic   spec;
    logic   spec_vis;
    coord_t spec_x1;
    coord_t spec_y1;
    coord_t spec_x2;
    coord_t spec_y2;
    coord_t sx;
    coord_t sy;
    logic   neg_x;
    logic   neg_y;
  } side_t;

  // lanes: 0 start x, 1 start y, 2 end x, 3 end y
  typedef struct packed {
    side_t             side;
    logic              par_vis;
    mag_t              te_d;
    mag_t              tl_d;
    logic [3:0][PW-1:0] prod;
  } job_t;

endpackage
`default_nettype wire

// ===== hdl/lsrc_front.sv =====
`default_nettype none
module lsrc_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire lsrc_pkg::win_t   win,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire lsrc_pkg::coord_t start_x,
  input  wire lsrc_pkg::coord_t start_y,
  input  wire lsrc_pkg::coord_t end_x,
  input  wire lsrc_pkg::coord_t end_y,
  output logic                  push,
  output lsrc_pkg::job_t        job,
  input  wire logic             q_full
);

  logic [3:0] v;
  logic adv;

  lsrc_pkg::side_t s1, s2, s3, s4;
  lsrc_pkg::mag_t dxa1, dya1, dxa2, dya2, dxa3, dya3;
  lsrc_pkg::num_t exn1, eyn1, lxn1, lyn1, exn2, eyn2, lxn2, lyn2;
  lsrc_pkg::xprod_t pa, pb, pc, pd;
  lsrc_pkg::mag_t te_n3, te_d3, tl_n3, tl_d3, te_d4, tl_d4;
  logic tl_bad3, tl_bad4;
  lsrc_pkg::prod_t pe, pf;
  logic [3:0][lsrc_pkg::PW-1:0] prod4;

  // stage 1 combinational terms
  lsrc_pkg::num_t dx, dy, n0, n1, m0, m1, ax, ay;
  lsrc_pkg::side_t s1_next;
  lsrc_pkg::coord_t lo, hi;
  logic opp;
  lsrc_pkg::num_t exn_next, eyn_next, lxn_next, lyn_next;

  // stage 3 combinational terms
  lsrc_pkg::num_t en, ln;
  lsrc_pkg::mag_t ed, ld;
  lsrc_pkg::mag_t te_n_next, te_d_next, tl_n_next, tl_d_next;

  assign adv      = !(v[3] && q_full);
  assign in_ready = adv;
  assign push     = v[3] && !q_full;

  always_comb begin
    dx = lsrc_pkg::num_t'(end_x) - lsrc_pkg::num_t'(start_x);
    dy = lsrc_pkg::num_t'(end_y) - lsrc_pkg::num_t'(start_y);
    n0 = lsrc_pkg::num_t'(start_x) - lsrc_pkg::num_t'(win.x_min);
    n1 = lsrc_pkg::num_t'(win.x_max) - lsrc_pkg::num_t'(start_x);
    m0 = lsrc_pkg::num_t'(start_y) - lsrc_pkg::num_t'(win.y_min);
    m1 = lsrc_pkg::num_t'(win.y_max) - lsrc_pkg::num_t'(start_y);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    // entering and leaving numerators over |dx| and |dy|
    exn_next = dx > 0 ? -n0 : -n1;
    lxn_next = dx > 0 ? n1 : n0;
    eyn_next = dy > 0 ? -m0 : -m1;
    lyn_next = dy > 0 ? m1 : m0;

    s1_next = '0;
    s1_next.sx    = start_x;
    s1_next.sy    = start_y;
    s1_next.neg_x = dx < 0;
    s1_next.neg_y = dy < 0;
    lo  = '0;
    hi  = '0;
    opp = 1'b0;
    if (dx == 0) begin
      // vertical or single point: clamp y span
      s1_next.spec = 1'b1;
      opp = (n0 < 0 && n1 > 0) || (n0 > 0 && n1 < 0);
      lo  = start_y < end_y ? start_y : end_y;
      hi  = start_y < end_y ? end_y : start_y;
      s1_next.spec_y1 = lo > win.y_min ? lo : win.y_min;
      s1_next.spec_y2 = hi < win.y_max ? hi : win.y_max;
      s1_next.spec_x1 = start_x;
      s1_next.spec_x2 = start_x;
      s1_next.spec_vis = !opp && (s1_next.spec_y1 <= s1_next.spec_y2);
    end else if (dy == 0) begin
      s1_next.spec = 1'b1;
      opp = (m0 < 0 && m1 > 0) || (m0 > 0 && m1 < 0);
      lo  = start_x < end_x ? start_x : end_x;
      hi  = start_x < end_x ? end_x : start_x;
      s1_next.spec_x1 = lo > win.x_min ? lo : win.x_min;
      s1_next.spec_x2 = hi < win.x_max ? hi : win.x_max;
      s1_next.spec_y1 = start_y;
      s1_next.spec_y2 = start_y;
      s1_next.spec_vis = !opp && (s1_next.spec_x1 <= s1_next.spec_x2);
    end
  end

  always_comb begin
    // te = max(0, ex, ey); tl = min(1, lx, ly)
    en = (pb > pa) ? eyn2 : exn2;
    ed = (pb > pa) ? dya2 : dxa2;
    ln = (pd < pc) ? lyn2 : lxn2;
    ld = (pd < pc) ? dya2 : dxa2;
    if (en <= 0) begin
      te_n_next = '0;
      te_d_next = lsrc_pkg::MW'(1);
    end else begin
      te_n_next = en[lsrc_pkg::MW-1:0];
      te_d_next = ed;
    end
    if (ln >= $signed({1'b0, ld})) begin
      tl_n_next = lsrc_pkg::MW'(1);
      tl_d_next = lsrc_pkg::MW'(1);
    end else begin
      tl_n_next = ln[lsrc_pkg::MW-1:0];
      tl_d_next = ld;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[2:0], in_valid};
    end
    if (adv) begin
      s1   <= s1_next;
      dxa1 <= ax[lsrc_pkg::MW-1:0];
      dya1 <= ay[lsrc_pkg::MW-1:0];
      exn1 <= exn_next;
      eyn1 <= eyn_next;
      lxn1 <= lxn_next;
      lyn1 <= lyn_next;

      s2   <= s1;
      dxa2 <= dxa1;
      dya2 <= dya1;
      exn2 <= exn1;
      eyn2 <= eyn1;
      lxn2 <= lxn1;
      lyn2 <= lyn1;
      pa   <= lsrc_pkg::XW'(exn1 * $signed({1'b0, dya1}));
      pb   <= lsrc_pkg::XW'(eyn1 * $signed({1'b0, dxa1}));
      pc   <= lsrc_pkg::XW'(lxn1 * $signed({1'b0, dya1}));
      pd   <= lsrc_pkg::XW'(lyn1 * $signed({1'b0, dxa1}));

      s3      <= s2;
      dxa3    <= dxa2;
      dya3    <= dya2;
      te_n3   <= te_n_next;
      te_d3   <= te_d_next;
      tl_n3   <= tl_n_next;
      tl_d3   <= tl_d_next;
      tl_bad3 <= ln <= 0;

      s4       <= s3;
      te_d4    <= te_d3;
      tl_d4    <= tl_d3;
      tl_bad4  <= tl_bad3;
      pe       <= lsrc_pkg::PW'(te_n3 * tl_d3);
      pf       <= lsrc_pkg::PW'(tl_n3 * te_d3);
      prod4[0] <= lsrc_pkg::PW'(dxa3 * te_n3);
      prod4[1] <= lsrc_pkg::PW'(dya3 * te_n3);
      prod4[2] <= lsrc_pkg::PW'(dxa3 * tl_n3);
      prod4[3] <= lsrc_pkg::PW'(dya3 * tl_n3);
    end
  end

  always_comb begin
    job.side    = s4;
    job.par_vis = !tl_bad4 && (pe < pf);
    job.te_d    = te_d4;
    job.tl_d    = tl_d4;
    job.prod    = prod4;
  end

endmodule
`default_nettype wire

// ===== hdl/lsrc_queue.sv =====
`default_nettype none
module lsrc_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire lsrc_pkg::job_t wr_job,
  output logic                full,
  input  wire logic           pop,
  output lsrc_pkg::job_t      rd_job,
  output logic                empty
);

  lsrc_pkg::job_t mem [lsrc_pkg::QD];
  logic [lsrc_pkg::QAW-1:0] head, tail;
  logic [lsrc_pkg::QAW:0] count;

  assign full   = count == (lsrc_pkg::QAW+1)'(lsrc_pkg::QD);
  assign empty  = count == '0;
  assign rd_job = mem[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + 1'b1;
      end
      if (pop) begin
        head <= head + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      mem[tail] <= wr_job;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/lsrc_back.sv =====
`default_nettype none
module lsrc_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             empty,
  input  wire lsrc_pkg::job_t   rd_job,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  visible,
  output lsrc_pkg::coord_t      clip_start_x,
  output lsrc_pkg::coord_t      clip_start_y,
  output lsrc_pkg::coord_t      clip_end_x,
  output lsrc_pkg::coord_t      clip_end_y
);

  localparam int NS = lsrc_pkg::CW;

  typedef struct packed {
    lsrc_pkg::side_t                 side;
    logic                            par_vis;
    lsrc_pkg::mag_t                  te_d;
    lsrc_pkg::mag_t                  tl_d;
    logic [3:0][lsrc_pkg::PW-1:0]    rem;
    logic [3:0][lsrc_pkg::CW-1:0]    quo;
  } dstage_t;

  dstage_t st [NS+1];
  logic [NS:0] stv;
  logic adv;
  dstage_t load;

  // one restoring step on all four lanes, quotient bit b
  function automatic dstage_t div_step(dstage_t s, int b);
    dstage_t r;
    lsrc_pkg::prod_t dsh;
    r = s;
    for (int l = 0; l < 4; l++) begin
      dsh = lsrc_pkg::PW'(l < 2 ? s.te_d : s.tl_d) << b;
      if (s.rem[l] >= dsh) begin
        r.rem[l] = s.rem[l] - dsh;
        r.quo[l][b] = 1'b1;
      end
    end
    return r;
  endfunction

  // trunc(s + sign * (q + r / d)) toward zero
  function automatic lsrc_pkg::coord_t finish(lsrc_pkg::coord_t s, logic neg,
                                              logic [lsrc_pkg::CW-1:0] q,
                                              lsrc_pkg::prod_t r);
    logic signed [lsrc_pkg::CW+1:0] qf, vv;
    logic rnz;
    rnz = r != '0;
    qf  = $signed({2'b00, q});
    if (neg) begin
      qf = -qf - (lsrc_pkg::CW+2)'(rnz);
    end
    vv = $signed({{2{s[lsrc_pkg::CW-1]}}, s}) + qf;
    if (rnz && vv < 0) begin
      vv = vv + 1'b1;
    end
    return vv[lsrc_pkg::CW-1:0];
  endfunction

  assign adv = !out_valid || out_ready;
  assign pop = adv && !empty;

  always_comb begin
    load.side    = rd_job.side;
    load.par_vis = rd_job.par_vis;
    load.te_d    = rd_job.te_d;
    load.tl_d    = rd_job.tl_d;
    load.rem     = rd_job.prod;
    load.quo     = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stv       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      stv       <= {stv[NS-1:0], pop};
      out_valid <= stv[NS];
    end
    if (adv) begin
      st[0] <= load;
      for (int k = 0; k < NS; k++) begin
        st[k+1] <= div_step(st[k], NS - 1 - k);
      end
      if (st[NS].side.spec) begin
        visible      <= st[NS].side.spec_vis;
        clip_start_x <= st[NS].side.spec_vis ? st[NS].side.spec_x1 : '0;
        clip_start_y <= st[NS].side.spec_vis ? st[NS].side.spec_y1 : '0;
        clip_end_x   <= st[NS].side.spec_vis ? st[NS].side.spec_x2 : '0;
        clip_end_y   <= st[NS].side.spec_vis ? st[NS].side.spec_y2 : '0;
      end else if (st[NS].par_vis) begin
        visible      <= 1'b1;
        clip_start_x <= finish(st[NS].side.sx, st[NS].side.neg_x, st[NS].quo[0],
                               st[NS].rem[0]);
        clip_start_y <= finish(st[NS].side.sy, st[NS].side.neg_y, st[NS].quo[1],
                               st[NS].rem[1]);
        clip_end_x   <= finish(st[NS].side.sx, st[NS].side.neg_x, st[NS].quo[2],
                               st[NS].rem[2]);
        clip_end_y   <= finish(st[NS].side.sy, st[NS].side.neg_y, st[NS].quo[3],
                               st[NS].rem[3]);
      end else begin
        visible      <= 1'b0;
        clip_start_x <= '0;
        clip_start_y <= '0;
        clip_end_x   <= '0;
        clip_end_y   <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/line_segment_rect_clipper_top.sv =====
`default_nettype none
// Cyrus-Beck clipper of one segment against the window in four registers.
// A segment is taken every cycle unless the last front stage holds one while
// the queue is full. It passes through 4 front stages that classify it and pick
// the entering and leaving fractions by cross-multiplication, the queue, then a
// 16-stage restoring divider with four lanes and an output register. Throughput
// is one segment per cycle while nothing stalls, set by the fully pipelined
// divider lanes. Write the window registers only while no segment is in flight.
module line_segment_rect_clipper_top (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire lsrc_pkg::coord_t cfg_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire lsrc_pkg::coord_t start_x,
  input  wire lsrc_pkg::coord_t start_y,
  input  wire lsrc_pkg::coord_t end_x,
  input  wire lsrc_pkg::coord_t end_y,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  visible,
  output lsrc_pkg::coord_t      clip_start_x,
  output lsrc_pkg::coord_t      clip_start_y,
  output lsrc_pkg::coord_t      clip_end_x,
  output lsrc_pkg::coord_t      clip_end_y
);

  lsrc_pkg::win_t win;
  lsrc_pkg::job_t wr_job, rd_job;
  logic q_push, q_full, q_pop, q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      win.x_min <= lsrc_pkg::X_MIN_RST;
      win.y_min <= lsrc_pkg::Y_MIN_RST;
      win.x_max <= lsrc_pkg::X_MAX_RST;
      win.y_max <= lsrc_pkg::Y_MAX_RST;
    end else if (cfg_we) begin
      case (lsrc_pkg::reg_idx_t'(cfg_index))
        lsrc_pkg::REG_X_MIN: win.x_min <= cfg_data;
        lsrc_pkg::REG_Y_MIN: win.y_min <= cfg_data;
        lsrc_pkg::REG_X_MAX: win.x_max <= cfg_data;
        lsrc_pkg::REG_Y_MAX: win.y_max <= cfg_data;
        default: ;
      endcase
    end
  end

  lsrc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .win      (win),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .start_x  (start_x),
    .start_y  (start_y),
    .end_x    (end_x),
    .end_y    (end_y),
    .push     (q_push),
    .job      (wr_job),
    .q_full   (q_full)
  );

  lsrc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_job (wr_job),
    .full   (q_full),
    .pop    (q_pop),
    .rd_job (rd_job),
    .empty  (q_empty)
  );

  lsrc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (q_empty),
    .rd_job       (rd_job),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .visible      (visible),
    .clip_start_x (clip_start_x),
    .clip_start_y (clip_start_y),
    .clip_end_x   (clip_end_x),
    .clip_end_y   (clip_end_y)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty) else $error("queue pop while empty");

  a_rejected_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !visible |-> clip_start_x == '0 && clip_start_y == '0 &&
                              clip_end_x == '0 && clip_end_y == '0)
    else $error("rejected request with nonzero coordinates");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid) else $error("result right after reset");

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;

  localparam int LATENCY = 40;
  localparam int WATCHDOG = 4000;
  localparam int N_RANDOM = 1030;

  typedef struct packed {
    logic             vis;
    lsrc_pkg::coord_t x1;
    lsrc_pkg::coord_t y1;
    lsrc_pkg::coord_t x2;
    lsrc_pkg::coord_t y2;
  } clip_t;

  class clip_scoreboard;
    clip_t  pending[$];
    longint xmin, ymin, xmax, ymax;
    int     errors;

    function void set_reg(lsrc_pkg::reg_idx_t idx, lsrc_pkg::coord_t v);
      case (idx)
        lsrc_pkg::REG_X_MIN: xmin = v;
        lsrc_pkg::REG_Y_MIN: ymin = v;
        lsrc_pkg::REG_X_MAX: xmax = v;
        lsrc_pkg::REG_Y_MAX: ymax = v;
        default: ;
      endcase
    endfunction

    // trunc(s + d*n/dd), dd > 0
    function longint lerp(longint s, longint d, longint n, longint dd);
      longint p, q;
      p = d * n;
      q = p / dd;
      if (p % dd != 0 && p < 0) q = q - 1;
      p = s + q;
      if ((d * n) % dd != 0 && p < 0) p = p + 1;
      return p;
    endfunction

    function void note_request(lsrc_pkg::coord_t a, lsrc_pkg::coord_t b,
                               lsrc_pkg::coord_t c, lsrc_pkg::coord_t e);
      longint sx, sy, ex, ey, dx, dy, tn, td, ten, ted, tln, tld;
      longint den[4], num[4];
      clip_t r;
      bit ok;
      sx = a; sy = b; ex = c; ey = e;
      dx = ex - sx; dy = ey - sy;
      den[0] = -dx; num[0] = sx - xmin;
      den[1] = dx;  num[1] = xmax - sx;
      den[2] = -dy; num[2] = sy - ymin;
      den[3] = dy;  num[3] = ymax - sy;
      r = '{0, 0, 0, 0, 0};
      ten = 0; ted = 1; tln = 1; tld = 1; ok = 1;
      if (dx == 0) begin
        if (!((num[0] < 0 && num[1] > 0) || (num[0] > 0 && num[1] < 0))) begin
          tn = (sy < ey) ? sy : ey; td = (sy < ey) ? ey : sy;
          tn = (tn > ymin) ? tn : ymin; td = (td < ymax) ? td : ymax;
          r = '{tn <= td, lsrc_pkg::coord_t'(sx), lsrc_pkg::coord_t'(tn),
                lsrc_pkg::coord_t'(sx), lsrc_pkg::coord_t'(td)};
        end
      end else if (dy == 0) begin
        if (!((num[2] < 0 && num[3] > 0) || (num[2] > 0 && num[3] < 0))) begin
          tn = (sx < ex) ? sx : ex; td = (sx < ex) ? ex : sx;
          tn = (tn > xmin) ? tn : xmin; td = (td < xmax) ? td : xmax;
          r = '{tn <= td, lsrc_pkg::coord_t'(tn), lsrc_pkg::coord_t'(sy),
                lsrc_pkg::coord_t'(td), lsrc_pkg::coord_t'(sy)};
        end
      end else begin
        for (int i = 0; i < 4 && ok; i++) begin
          if (den[i] < 0) begin
            tn = -num[i]; td = -den[i];
            if (tn * tld > tln * td) ok = 0;
            else if (tn * ted > ten * td) begin ten = tn; ted = td; end
          end else begin
            tn = num[i]; td = den[i];
            if (tn * ted < ten * td) ok = 0;
            else if (tn * tld < tln * td) begin tln = tn; tld = td; end
          end
        end
        if (ok && ten * tld < tln * ted)
          r = '{1, lsrc_pkg::coord_t'(lerp(sx, dx, ten, ted)),
                lsrc_pkg::coord_t'(lerp(sy, dy, ten, ted)),
                lsrc_pkg::coord_t'(lerp(sx, dx, tln, tld)),
                lsrc_pkg::coord_t'(lerp(sy, dy, tln, tld))};
      end
      if (!r.vis) r = '{0, 0, 0, 0, 0};
      pending.push_back(r);
    endfunction

    function void check_result(clip_t got);
      clip_t w;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result vis=%0d", got.vis);
        return;
      end
      w = pending.pop_front();
      if (got !== w) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                   w.vis, $signed(w.x1), $signed(w.y1), $signed(w.x2), $signed(w.y2),
                   got.vis, $signed(got.x1), $signed(got.y1), $signed(got.x2),
                   $signed(got.y2));
      end
    endfunction
  endclass

  logic clk, rst, cfg_we, in_valid, in_ready, out_valid, out_ready, visible;
  logic [1:0] cfg_index;
  lsrc_pkg::coord_t cfg_data, start_x, start_y, end_x, end_y;
  lsrc_pkg::coord_t clip_start_x, clip_start_y, clip_end_x, clip_end_y;
  clip_scoreboard sb;
  int idle_cycles, hold_off;

  line_segment_rect_clipper_top u_top (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  task automatic write_reg(lsrc_pkg::reg_idx_t idx, lsrc_pkg::coord_t v);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_window(lsrc_pkg::coord_t x0, lsrc_pkg::coord_t y0,
                            lsrc_pkg::coord_t x1, lsrc_pkg::coord_t y1);
    write_reg(lsrc_pkg::REG_X_MIN, x0);
    write_reg(lsrc_pkg::REG_Y_MIN, y0);
    write_reg(lsrc_pkg::REG_X_MAX, x1);
    write_reg(lsrc_pkg::REG_Y_MAX, y1);
  endtask

  // called at a negedge
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  // called at a negedge; returns at a negedge after acceptance
  task automatic send_segment(lsrc_pkg::coord_t a, lsrc_pkg::coord_t b,
                              lsrc_pkg::coord_t c, lsrc_pkg::coord_t e, bit gap);
    int n;
    n = gap ? int'($urandom_range(0, 9)) : 0;
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1; start_x <= a; start_y <= b; end_x <= c; end_y <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(a, b, c, e);
    @(negedge clk);
  endtask

  function automatic lsrc_pkg::coord_t rnd_coord(lsrc_pkg::coord_t lo,
                                                 lsrc_pkg::coord_t hi);
    case ($urandom_range(0, 3))
      0: return lsrc_pkg::coord_t'($urandom);
      1: return lsrc_pkg::coord_t'($urandom_range(0, 3) == 0 ? 16'h8000 : 16'h7fff);
      default: return lsrc_pkg::coord_t'(int'(lo) - 200 + int'($urandom_range(0, 400 +
                 ((int'(hi) - int'(lo)) & 32'hffff))));
    endcase
  endfunction

  task automatic random_phase(int n, lsrc_pkg::coord_t x0, lsrc_pkg::coord_t y0,
                              lsrc_pkg::coord_t x1, lsrc_pkg::coord_t y1);
    lsrc_pkg::coord_t a, b, c, e;
    for (int i = 0; i < n; i++) begin
      a = rnd_coord(x0, x1); b = rnd_coord(y0, y1);
      c = rnd_coord(x0, x1); e = rnd_coord(y0, y1);
      case ($urandom_range(0, 7))
        0: c = a;
        1: e = b;
        default: ;
      endcase
      send_segment(a, b, c, e, $urandom_range(0, 3) != 0);
    end
  endtask

  // receiver
  initial begin
    out_ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off > 0) begin
        out_ready <= 0;
        repeat (hold_off) @(negedge clk);
        hold_off = 0;
      end else if ($urandom_range(0, 2) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result('{visible, clip_start_x, clip_start_y, clip_end_x, clip_end_y});
      @(negedge clk);
    end
  end

  // watchdog
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("** line_segment_rect_clipper_top: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    sb.xmin = 0; sb.ymin = 0; sb.xmax = 1023; sb.ymax = 767;
    hold_off = 0;
    rst = 1; cfg_we = 0; cfg_index = 0; cfg_data = 0; in_valid = 0;
    start_x = 0; start_y = 0; end_x = 0; end_y = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;
    // reset window, directed cases
    send_segment(-100, 100, 2000, 500, 0);
    send_segment(500, -50, 500, 900, 0);
    send_segment(-5, 10, -5, 300, 0);
    send_segment(100, 800, 200, 800, 0);
    send_segment(50, 50, 50, 50, 0);
    send_segment(2000, 2000, 3000, 3000, 0);
    send_segment(1023, 767, 0, 0, 0);
    send_segment(-32768, -32768, 32767, 32767, 0);
    send_segment(32767, -32768, -32768, 32767, 0);
    send_segment(-32768, 0, 32767, 0, 0);
    send_segment(0, 32767, 0, -32768, 0);
    send_segment(10, 10, 20, 20, 0);
    send_segment(-10, 5, 5, -10, 0);
    send_segment(1100, 700, 1000, 900, 0);
    drain();
    set_window(-32768, -32768, 32767, 32767);
    send_segment(-32768, -32768, 32767, 32767, 0);
    send_segment(32767, 32767, -32768, -32767, 0);
    send_segment(-32768, 32767, 32767, -32768, 0);
    drain();
    // inverted window
    set_window(100, 100, -100, -100);
    send_segment(-200, 0, 200, 0, 0);
    send_segment(0, -200, 0, 200, 0);
    send_segment(-200, -150, 200, 150, 0);
    drain();
    set_window(-300, -200, 300, 200);
    random_phase(N_RANDOM / 4, -300, -200, 300, 200);
    // long receiver stall while input keeps coming
    hold_off = 300;
    random_phase(40, -300, -200, 300, 200);
    drain();
    set_window(-32768, -32768, 32767, 32767);
    random_phase(N_RANDOM / 4, -32768, -32768, 32767, 32767);
    drain();
    set_window(5, -7, 5, 9);
    random_phase(N_RANDOM / 8, 0, -10, 10, 10);
    drain();
    set_window(0, 0, 1023, 767);
    random_phase(N_RANDOM / 4, 0, 0, 1023, 767);
    drain();
    set_window(32000, -32768, -32000, 32767);
    random_phase(N_RANDOM / 8, -32000, -32768, 32000, 32767);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("** line_segment_rect_clipper_top: PASSED **");
    else
      $display("** line_segment_rect_clipper_top: FAILED **");
    $finish;
  end

endmodule
